FILE: sv/fxa_pkg.sv
// Shared constants, mode codes and pipeline side-band type for the Q24.8 ALU.
package fxa_pkg;

  localparam int DEF_FRACTION_BITS = 8;
  localparam int VALUE_W           = 32;
  localparam int MODE_W            = 4;

  localparam logic [MODE_W-1:0] MODE_ADD      = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SUB      = 4'd1;
  localparam logic [MODE_W-1:0] MODE_MUL      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DIV      = 4'd3;
  localparam logic [MODE_W-1:0] MODE_GT       = 4'd4;
  localparam logic [MODE_W-1:0] MODE_LT       = 4'd5;
  localparam logic [MODE_W-1:0] MODE_GE       = 4'd6;
  localparam logic [MODE_W-1:0] MODE_LE       = 4'd7;
  localparam logic [MODE_W-1:0] MODE_EQ       = 4'd8;
  localparam logic [MODE_W-1:0] MODE_NE       = 4'd9;
  localparam logic [MODE_W-1:0] MODE_MIN      = 4'd10;
  localparam logic [MODE_W-1:0] MODE_MAX      = 4'd11;
  localparam logic [MODE_W-1:0] MODE_INC      = 4'd12;
  localparam logic [MODE_W-1:0] MODE_DEC      = 4'd13;
  localparam logic [MODE_W-1:0] MODE_FROM_INT = 4'd14;
  localparam logic [MODE_W-1:0] MODE_TO_INT   = 4'd15;

  // Result side-band that rides along the divider chain.
  typedef struct packed {
    logic               is_div;
    logic               neg_q;
    logic               dz;
    logic               cmp;
    logic [VALUE_W-1:0] value;
  } side_t;

endpackage

FILE: sv/fxa_if.sv
// Request and result channel interfaces for the fixed-point ALU.
interface fxa_req_if;
  import fxa_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic signed [VALUE_W-1:0] operand_a;
  logic signed [VALUE_W-1:0] operand_b;
  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fxa_rsp_if;
  import fxa_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [VALUE_W-1:0] result_value;
  logic               compare_true;
  logic               divide_by_zero;
  modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
  modport sink   (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

FILE: sv/fxa_front.sv
// Front stages: simple ops, multiplier and divider operand prep (two register stages).
module fxa_front import fxa_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int DW            = VALUE_W + FRACTION_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic signed [VALUE_W-1:0] in_a,
  input  logic signed [VALUE_W-1:0] in_b,
  output logic                      out_valid,
  output side_t                     out_side,
  output logic [DW-1:0]             out_quo,
  output logic [VALUE_W-1:0]        out_dsr
);

  localparam logic [VALUE_W:0]     TI_BIAS  = (33'd1 << FRACTION_BITS) - 33'd1;
  localparam logic [2*VALUE_W-1:0] MUL_BIAS = (64'd1 << FRACTION_BITS) - 64'd1;

  logic                        v1_r, v2_r;
  logic                        mul1_r;
  side_t                       side1_r, side1_nxt, side2_r, side2_nxt;
  logic signed [2*VALUE_W-1:0] prod1_r;
  logic [DW-1:0]               quo1_r, quo1_nxt, quo2_r;
  logic [VALUE_W-1:0]          dsr1_r, dsr1_nxt, dsr2_r;

  logic signed [VALUE_W:0]     ti_sum, ti_shift;
  logic                        lt, eq;
  logic [VALUE_W-1:0]          abs_a;
  logic signed [2*VALUE_W-1:0] mul_sum, mul_shift;

  always_comb begin
    lt       = in_a < in_b;
    eq       = in_a == in_b;
    ti_sum   = {in_a[VALUE_W-1], in_a} + (in_a[VALUE_W-1] ? TI_BIAS : '0);
    ti_shift = ti_sum >>> FRACTION_BITS;
    abs_a    = in_a[VALUE_W-1] ? VALUE_W'(-in_a) : VALUE_W'(in_a);
    dsr1_nxt = in_b[VALUE_W-1] ? VALUE_W'(-in_b) : VALUE_W'(in_b);
    quo1_nxt = DW'(abs_a) << FRACTION_BITS;

    side1_nxt        = '0;
    side1_nxt.is_div = in_mode == MODE_DIV;
    side1_nxt.neg_q  = in_a[VALUE_W-1] ^ in_b[VALUE_W-1];
    side1_nxt.dz     = (in_mode == MODE_DIV) && (in_b == '0);
    case (in_mode)
      MODE_ADD:      side1_nxt.value = in_a + in_b;
      MODE_SUB:      side1_nxt.value = in_a - in_b;
      MODE_GT:       side1_nxt.cmp   = !lt && !eq;
      MODE_LT:       side1_nxt.cmp   = lt;
      MODE_GE:       side1_nxt.cmp   = !lt;
      MODE_LE:       side1_nxt.cmp   = lt || eq;
      MODE_EQ:       side1_nxt.cmp   = eq;
      MODE_NE:       side1_nxt.cmp   = !eq;
      MODE_MIN:      side1_nxt.value = lt ? in_a : in_b;
      MODE_MAX:      side1_nxt.value = (!lt && !eq) ? in_a : in_b;
      MODE_INC:      side1_nxt.value = in_a + 32'sd1;
      MODE_DEC:      side1_nxt.value = in_a - 32'sd1;
      MODE_FROM_INT: side1_nxt.value = in_a <<< FRACTION_BITS;
      MODE_TO_INT:   side1_nxt.value = ti_shift[VALUE_W-1:0];
      default:       side1_nxt.value = '0;
    endcase
  end

  // Multiply finish: truncate toward zero by biasing negatives before the shift.
  always_comb begin
    mul_sum   = prod1_r + (prod1_r[2*VALUE_W-1] ? MUL_BIAS : '0);
    mul_shift = mul_sum >>> FRACTION_BITS;
    side2_nxt = side1_r;
    if (mul1_r) begin
      side2_nxt.value = mul_shift[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul1_r  <= in_mode == MODE_MUL;
      side1_r <= side1_nxt;
      prod1_r <= in_a * in_b;
      quo1_r  <= quo1_nxt;
      dsr1_r  <= dsr1_nxt;
      side2_r <= side2_nxt;
      quo2_r  <= quo1_r;
      dsr2_r  <= dsr1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_side  = side2_r;
  assign out_quo   = quo2_r;
  assign out_dsr   = dsr2_r;

endmodule

FILE: sv/fxa_div_step.sv
// One restoring-division stage: produces one quotient bit per register stage.
module fxa_div_step import fxa_pkg::*; #(
  parameter int DW = VALUE_W + DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [VALUE_W-1:0] in_rem,
  input  logic [DW-1:0]      in_quo,
  input  logic [VALUE_W-1:0] in_dsr,
  output logic               out_valid,
  output side_t              out_side,
  output logic [VALUE_W-1:0] out_rem,
  output logic [DW-1:0]      out_quo,
  output logic [VALUE_W-1:0] out_dsr
);

  logic               v_r;
  side_t              side_r;
  logic [VALUE_W-1:0] rem_r, rem_nxt, dsr_r;
  logic [DW-1:0]      quo_r, quo_nxt;
  logic [VALUE_W:0]   trial, diff;
  logic               fits;

  always_comb begin
    trial   = {in_rem, in_quo[DW-1]};
    diff    = trial - {1'b0, in_dsr};
    fits    = trial >= {1'b0, in_dsr};
    rem_nxt = fits ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
    quo_nxt = {in_quo[DW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      dsr_r  <= in_dsr;
    end
  end

  assign out_valid = v_r;
  assign out_side  = side_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_dsr   = dsr_r;

endmodule

FILE: sv/fxa_back.sv
// Result stage: applies quotient sign, zeroes divide-by-zero results and holds the output register.
module fxa_back import fxa_pkg::*; #(
  parameter int DW = VALUE_W + DEF_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  side_t              in_side,
  input  logic [DW-1:0]      in_quo,
  output logic               out_valid,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_cmp,
  output logic               out_dz
);

  logic               v_r;
  logic [VALUE_W-1:0] value_r, value_nxt, q_lo;
  logic               cmp_r, dz_r;

  always_comb begin
    q_lo      = in_quo[VALUE_W-1:0];
    value_nxt = in_side.value;
    if (in_side.is_div) begin
      if (in_side.dz) begin
        value_nxt = '0;
      end else begin
        value_nxt = in_side.neg_q ? VALUE_W'(-q_lo) : q_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= value_nxt;
      cmp_r   <= in_side.cmp;
      dz_r    <= in_side.dz;
    end
  end

  assign out_valid = v_r;
  assign out_value = value_r;
  assign out_cmp   = cmp_r;
  assign out_dz    = dz_r;

endmodule

FILE: sv/fixed_point_q24_8_alu.sv
// Top level of the pipelined signed Q24.8 fixed-point ALU.
//
//   channel   role    signals                                   request
//   in_ch     sink    valid ready mode operand_a operand_b       one operation
//   out_ch    source  valid ready result_value compare_true      one result
//                     divide_by_zero
//
// One request per cycle sustained while out_ch does not stall; the divider
// retires one quotient bit per stage over the 32+FRACTION_BITS bit scaled
// dividend.
// rst_n is synchronous, active low, and clears only the stage valid bits.
// A stall at out_ch freezes the whole pipe in place; in_ch.ready drops for
// exactly those cycles, so nothing is dropped or repeated.
module fixed_point_q24_8_alu import fxa_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  fxa_req_if.sink   in_ch,
  fxa_rsp_if.source out_ch
);

  localparam int DW = VALUE_W + FRACTION_BITS;

  logic               en;
  logic               v_s   [0:DW];
  side_t              side_s[0:DW];
  logic [VALUE_W-1:0] rem_s [0:DW];
  logic [DW-1:0]      quo_s [0:DW];
  logic [VALUE_W-1:0] dsr_s [0:DW];
  logic [VALUE_W-1:0] res_value;

  // Global advance: the output register is free or being drained.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  fxa_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .DW            (DW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_a      (in_ch.operand_a),
    .in_b      (in_ch.operand_b),
    .out_valid (v_s[0]),
    .out_side  (side_s[0]),
    .out_quo   (quo_s[0]),
    .out_dsr   (dsr_s[0])
  );

  // Partial remainder starts empty.
  assign rem_s[0] = '0;

  for (genvar i = 0; i < DW; i++) begin : g_div
    fxa_div_step #(
      .DW (DW)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (v_s[i]),
      .in_side   (side_s[i]),
      .in_rem    (rem_s[i]),
      .in_quo    (quo_s[i]),
      .in_dsr    (dsr_s[i]),
      .out_valid (v_s[i+1]),
      .out_side  (side_s[i+1]),
      .out_rem   (rem_s[i+1]),
      .out_quo   (quo_s[i+1]),
      .out_dsr   (dsr_s[i+1])
    );
  end

  fxa_back #(
    .DW (DW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v_s[DW]),
    .in_side   (side_s[DW]),
    .in_quo    (quo_s[DW]),
    .out_valid (out_ch.valid),
    .out_value (res_value),
    .out_cmp   (out_ch.compare_true),
    .out_dz    (out_ch.divide_by_zero)
  );

  assign out_ch.result_value = res_value;

  // Divide by zero forces a zero value and no compare flag.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_by_zero |-> res_value == '0 && !out_ch.compare_true)
    else $error("divide-by-zero result not clean");

  // Comparisons report only through compare_true.
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.compare_true |-> res_value == '0)
    else $error("compare result carries a value");

  // Reset empties the pipe.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  // While stalled the pipe does not take requests.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("request taken during stall");

endmodule
